### rtl/ipe_pkg.sv
// ----------------------------------------------------------------------------
// ipe_pkg
// Shared constants and types for the add/sub/paren expression evaluator.
// ----------------------------------------------------------------------------
package ipe_pkg;

    localparam int MAX_NESTING = 32;
    localparam int LEVEL_W     = $clog2(MAX_NESTING + 1);
    localparam int DATA_W      = 32;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    typedef struct packed {
        logic [DATA_W-1:0] total;
        logic              neg;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

endpackage

### rtl/ipe_stack_cell.sv
// ----------------------------------------------------------------------------
// ipe_stack_cell
// One entry of the shift stack: loads from above on push, from below on pop.
// ----------------------------------------------------------------------------
module ipe_stack_cell (
    input  logic                aclk,
    input  ipe_pkg::stack_ctl_t ctl,
    input  ipe_pkg::entry_t     above,
    input  ipe_pkg::entry_t     below,
    output ipe_pkg::entry_t     q
);

    ipe_pkg::entry_t q_reg;

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            q_reg <= above;
        end else if (ctl.pop) begin
            q_reg <= below;
        end
    end

    assign q = q_reg;

endmodule

### rtl/ipe_stack.sv
// ----------------------------------------------------------------------------
// ipe_stack
// Row of stack cells; the top of stack is always cell 0.
// ----------------------------------------------------------------------------
module ipe_stack (
    input  logic                aclk,
    input  ipe_pkg::stack_ctl_t ctl,
    input  ipe_pkg::entry_t     push_data,
    output ipe_pkg::entry_t     top
);

    ipe_pkg::entry_t cell_q [ipe_pkg::MAX_NESTING];

    genvar i;
    generate
        for (i = 0; i < ipe_pkg::MAX_NESTING; i++) begin : g_cell
            ipe_pkg::entry_t above;
            ipe_pkg::entry_t below;

            if (i == 0) begin : g_first
                assign above = push_data;
            end else begin : g_mid_a
                assign above = cell_q[i-1];
            end

            if (i == ipe_pkg::MAX_NESTING - 1) begin : g_last
                assign below = cell_q[i];
            end else begin : g_mid_b
                assign below = cell_q[i+1];
            end

            ipe_stack_cell u_cell (
                .aclk  (aclk),
                .ctl   (ctl),
                .above (above),
                .below (below),
                .q     (cell_q[i])
            );
        end
    endgenerate

    assign top = cell_q[0];

endmodule

### rtl/infix_add_sub_paren_evaluator_core.sv
// ----------------------------------------------------------------------------
// infix_add_sub_paren_evaluator_core
// Streaming evaluator of +, - and parenthesized decimal expressions.
//
//   channel  ports                               role
//   s_       s_valid s_ready s_char_code s_is_last  one character per item
//   m_       m_valid m_ready m_value m_nesting_error one result per expression
//
// One character is taken every cycle while s_ready is high; the saved context lives in a shift
// stack of MAX_NESTING cells that moves by one entry per push or pop.
// A result appears the cycle after its last character is accepted.
// s_ready drops only while a result is held and m_ready is low.
// aresetn is synchronous and active low; the stack holds no reset state.
// ----------------------------------------------------------------------------
module infix_add_sub_paren_evaluator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_value,
    output logic        m_nesting_error
);

    localparam int DW = ipe_pkg::DATA_W;
    localparam int LW = ipe_pkg::LEVEL_W;

    logic [DW-1:0] total_reg, total_next;
    logic [DW-1:0] num_reg, num_next;
    logic          neg_reg, neg_next;
    logic [LW-1:0] level_reg, level_next;
    logic          err_reg, err_next;

    logic          out_valid_reg;
    logic [DW-1:0] res_total_reg;
    logic [DW-1:0] res_num_reg;
    logic          res_neg_reg;
    logic          res_err_reg;

    logic                accept;
    logic                is_digit;
    logic [DW-1:0]       num_x10;
    logic [DW-1:0]       operand;
    logic [DW-1:0]       sum;
    logic [DW-1:0]       pop_total;
    logic                can_push;
    logic                can_pop;
    ipe_pkg::stack_ctl_t stack_ctl;
    ipe_pkg::entry_t     push_data;
    logic                top_neg;
    ipe_pkg::entry_t     top;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_digit = s_char_code inside {[ipe_pkg::CH_ZERO:ipe_pkg::CH_NINE]};
    assign num_x10  = {num_reg[DW-4:0], 3'b000} + {num_reg[DW-2:0], 1'b0}
                    + {{(DW-4){1'b0}}, s_char_code[3:0]};
    assign operand  = neg_reg ? (~num_reg + 1'b1) : num_reg;
    assign sum      = total_reg + operand;
    assign top_neg  = top.neg;
    assign pop_total = top_neg ? (top.total - sum) : (top.total + sum);
    assign can_push = level_reg < LW'(ipe_pkg::MAX_NESTING);
    assign can_pop  = level_reg != '0;

    assign push_data = {total_reg, neg_reg};

    always_comb begin
        total_next = total_reg;
        num_next   = num_reg;
        neg_next   = neg_reg;
        level_next = level_reg;
        err_next   = err_reg;
        stack_ctl  = '0;
        if (is_digit) begin
            num_next = num_x10;
        end else begin
            case (s_char_code)
                ipe_pkg::CH_PLUS, ipe_pkg::CH_MINUS: begin
                    total_next = sum;
                    num_next   = '0;
                    neg_next   = (s_char_code == ipe_pkg::CH_MINUS);
                end
                ipe_pkg::CH_LPAREN: begin
                    if (can_push) begin
                        stack_ctl.push = accept;
                        level_next     = level_reg + 1'b1;
                    end else begin
                        err_next = 1'b1;
                    end
                    total_next = '0;
                    neg_next   = 1'b0;
                end
                ipe_pkg::CH_RPAREN: begin
                    if (can_pop) begin
                        stack_ctl.pop = accept;
                        level_next    = level_reg - 1'b1;
                        total_next    = pop_total;
                    end else begin
                        total_next = sum;
                        err_next   = 1'b1;
                    end
                    num_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    ipe_stack u_stack (
        .aclk      (aclk),
        .ctl       (stack_ctl),
        .push_data (push_data),
        .top       (top)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            num_reg   <= '0;
            neg_reg   <= 1'b0;
            level_reg <= '0;
            err_reg   <= 1'b0;
        end else if (accept) begin
            if (s_is_last) begin
                total_reg <= '0;
                num_reg   <= '0;
                neg_reg   <= 1'b0;
                level_reg <= '0;
                err_reg   <= 1'b0;
            end else begin
                total_reg <= total_next;
                num_reg   <= num_next;
                neg_reg   <= neg_next;
                level_reg <= level_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept && s_is_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_is_last) begin
            res_total_reg <= total_next;
            res_num_reg   <= num_next;
            res_neg_reg   <= neg_next;
            res_err_reg   <= err_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_value         = res_total_reg
                           + (res_neg_reg ? (~res_num_reg + 1'b1) : res_num_reg);
    assign m_nesting_error = res_err_reg;

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LW'(ipe_pkg::MAX_NESTING))
        else $error("stack level beyond depth");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_is_last) |=> m_valid)
        else $error("no result after last item");

    a_last_clears_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_is_last) |=> (level_reg == '0 && !err_reg))
        else $error("state not cleared after last item");

    a_push_pop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stack_ctl.push && stack_ctl.pop))
        else $error("push and pop together");

endmodule
